/* src/ple_pkg.sv */
// shared types and constants for the positional list engine
package ple_pkg;

    localparam int unsigned FUNC_W = 3;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_REMOVE = 3'd1,
        FN_MODIFY = 3'd2,
        FN_READ   = 3'd3,
        FN_FIND   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

/* src/positional_list_engine_unit.sv */
// top level of the positional list engine
// an accepted request is captured, then the result is registered in the execute state and shown in the report state
// a new request is taken only in the idle state, after the capture/execute/report sequence has finished
// busy is low in idle and stays high after acceptance through the result cycle
// reset clears the controller and the entry count; entry cells are not cleared
// the receiver cannot stall: the result shows for one cycle under o_valid
module positional_list_engine_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_func,
    input  logic [7:0]                        i_position,
    input  logic signed [31:0]                i_value,
    output logic                              o_valid,
    output logic signed [31:0]                o_value_out,
    output logic [4:0]                        o_found_position,
    output logic                              o_ok,
    output logic [4:0]                        o_count,
    output logic                              o_empty_res
);

    ple_pkg::t_cmd cmd;

    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    ple_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_func),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_ok             (o_ok),
        .o_count          (o_count),
        .o_empty_res      (o_empty_res)
    );

    a_empty_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_empty_res == (o_count == 5'd0)))
        else $error("empty flag disagrees with count");

    a_found_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found_position != 5'd0) |-> o_ok)
        else $error("found position without ok");

    a_valid_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result not delivered two cycles after acceptance");

endmodule

/* src/ple_ctrl.sv */
// controller state machine: capture, execute, report
module ple_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    output ple_pkg::t_cmd o_cmd
);

    ple_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ple_pkg::ST_IDLE: begin
                if (start) n_state = ple_pkg::ST_EXEC;
            end
            ple_pkg::ST_EXEC: n_state = ple_pkg::ST_DONE;
            ple_pkg::ST_DONE: n_state = ple_pkg::ST_IDLE;
            default:          n_state = ple_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy          = 1'b1;
        o_valid       = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ple_pkg::ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ple_pkg::ST_EXEC: o_cmd.execute = 1'b1;
            ple_pkg::ST_DONE: o_valid = 1'b1;
            default:          busy = 1'b1;
        endcase
    end

endmodule

/* src/ple_dp.sv */
// datapath: shifting entry cells, position checks and priority search
module ple_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ple_pkg::t_cmd                     i_cmd,
    input  logic [ple_pkg::FUNC_W-1:0]        i_func,
    input  logic [ple_pkg::POS_W-1:0]         i_position,
    input  logic signed [ple_pkg::DATA_W-1:0] i_value,
    output logic signed [ple_pkg::DATA_W-1:0] o_value_out,
    output logic [ple_pkg::CNT_W-1:0]         o_found_position,
    output logic                              o_ok,
    output logic [ple_pkg::CNT_W-1:0]         o_count,
    output logic                              o_empty_res
);

    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (NW > ple_pkg::POS_W) ? NW : ple_pkg::POS_W;

    logic [ple_pkg::DATA_W-1:0] r_cells [DEPTH];
    logic [ple_pkg::DATA_W-1:0] n_cells [DEPTH];
    logic [NW-1:0]              r_cnt, n_cnt;
    logic [ple_pkg::FUNC_W-1:0] r_func;
    logic [PW-1:0]              r_pos;
    logic [ple_pkg::DATA_W-1:0] r_val;
    logic [ple_pkg::DATA_W-1:0] r_vout, n_vout;
    logic [ple_pkg::CNT_W-1:0]  r_fpos, n_fpos;
    logic                       r_ok, n_ok;

    logic [PW-1:0]         cnt_w;
    logic                  pos_in;
    logic [DEPTH-1:0]      hit;
    logic [NW-1:0]         hit_idx;
    logic                  hit_any;
    logic [ple_pkg::DATA_W-1:0] sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.execute) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_pos  <= PW'(i_position);
            r_val  <= i_value;
        end
        if (i_cmd.execute) begin
            r_cells <= n_cells;
            r_vout  <= n_vout;
            r_fpos  <= n_fpos;
            r_ok    <= n_ok;
        end
    end

    assign cnt_w  = PW'(r_cnt);
    assign pos_in = (r_pos != '0) && (r_pos <= cnt_w);

    always_comb begin
        sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_pos == PW'(i + 1)) sel = r_cells[i];
        end
    end

    // parallel compare then priority encode, lowest position wins
    always_comb begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            hit[i] = (r_cells[i] == r_val) && (NW'(i) < r_cnt);
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = NW'(i + 1);
                hit_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_cells = r_cells;
        n_cnt   = r_cnt;
        n_vout  = '0;
        n_fpos  = '0;
        n_ok    = 1'b0;
        case (r_func)
            ple_pkg::FN_INSERT: begin
                if ((r_cnt < NW'(DEPTH)) && (r_pos != '0) && (r_pos <= cnt_w + PW'(1))) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (PW'(i + 1) == r_pos) begin
                            n_cells[i] = r_val;
                        end else if ((PW'(i + 1) > r_pos) && (i > 0)) begin
                            n_cells[i] = r_cells[i-1];
                        end
                    end
                    n_cnt = r_cnt + NW'(1);
                    n_ok  = 1'b1;
                end
            end
            ple_pkg::FN_REMOVE: begin
                if (pos_in) begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (PW'(i + 1) >= r_pos) n_cells[i] = r_cells[i+1];
                    end
                    n_vout = sel;
                    n_cnt  = r_cnt - NW'(1);
                    n_ok   = 1'b1;
                end
            end
            ple_pkg::FN_MODIFY: begin
                if (pos_in) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (PW'(i + 1) == r_pos) n_cells[i] = r_val;
                    end
                    n_ok = 1'b1;
                end
            end
            ple_pkg::FN_READ: begin
                if (pos_in) begin
                    n_vout = sel;
                    n_ok   = 1'b1;
                end
            end
            ple_pkg::FN_FIND: begin
                n_fpos = ple_pkg::CNT_W'(hit_idx);
                n_ok   = hit_any;
            end
            default: n_ok = 1'b0;
        endcase
    end

    assign o_value_out      = r_vout;
    assign o_found_position = r_fpos;
    assign o_ok             = r_ok;
    assign o_count          = ple_pkg::CNT_W'(r_cnt);
    assign o_empty_res      = (r_cnt == '0);

endmodule
